[rtl/circular_turn_rotation_list_assert.svh]
// Assertion macros for the turn-rotation ring.
// Each macro takes a label, the clock, the active-low reset and the property terms.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef CIRCULAR_TURN_ROTATION_LIST_ASSERT_SVH
`define CIRCULAR_TURN_ROTATION_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CTRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctrl: same-cycle check failed");

// next-cycle implication
`define CTRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctrl: next-cycle check failed");

`else

`define CTRL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTRL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/ctrl_pkg.sv]
package ctrl_pkg;

    // fixed field widths of the command and result words
    localparam int ID_PORT_W  = 16;
    localparam int CNT_PORT_W = 5;
    localparam int ST_W       = 3;

    // parameter defaults
    localparam int DEF_MAX_MEMBERS = 16;
    localparam int DEF_ID_BITS     = 16;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_ADV1   = 2'd2,
        OP_ADV2   = 2'd3
    } t_op;

    // status codes
    localparam logic [ST_W-1:0] ST_DONE         = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY        = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL         = 3'd3;
    localparam logic [ST_W-1:0] ST_LAST_REMOVED = 3'd4;

    // command word
    typedef struct packed {
        logic [1:0]           operation;
        logic [ID_PORT_W-1:0] player_id;
    } t_cmd;

    // result word
    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic [ID_PORT_W-1:0]  current_id;
        logic                  current_valid;
        logic [CNT_PORT_W-1:0] member_count;
        logic                  sole_member;
    } t_res;

    // control from the sequencer to one cell
    typedef struct packed {
        logic add_here;   // load the key into this slot
        logic remove_en;  // remove pass: slots at or past the first match shift down
    } t_cell_cmd;

    // status from one cell
    typedef struct packed {
        logic hit;        // live slot whose ID equals the key
        logic found;      // a hit here or in any slot toward the head
    } t_cell_stat;

endpackage

[rtl/ctrl_stream_if.sv]
// valid/ready channel carrying one word of type T
interface ctrl_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ctrl_cell.sv]
// One slot of the ring: holds one member ID, compares it with the key and
// takes its neighbor's ID when a removal closes the gap.
module ctrl_cell import ctrl_pkg::*; #(
    parameter int ID_W = DEF_ID_BITS
) (
    input  logic            i_clk,
    input  logic [ID_W-1:0] i_key,
    input  logic [ID_W-1:0] i_next_id,
    input  logic            i_found,
    input  logic            i_active,
    input  t_cell_cmd       i_cmd,
    output logic [ID_W-1:0] o_id,
    output t_cell_stat      o_stat
);

    logic [ID_W-1:0] r_id;
    logic [ID_W-1:0] n_id;

    // match and first-match chain
    assign o_stat.hit   = i_active && (r_id == i_key);
    assign o_stat.found = i_found || o_stat.hit;

    // load on add, shift down from the first match on remove
    always_comb begin
        n_id = r_id;
        if (i_cmd.add_here) begin
            n_id = i_key;
        end else if (i_cmd.remove_en && o_stat.found) begin
            n_id = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id = r_id;

endmodule

[rtl/circular_turn_rotation_list.sv]
// Turn-rotation ring of up to MAX_MEMBERS member IDs in insertion order with
// a current-member pointer. Commands (add, remove first match from the head,
// advance one, advance two) arrive on i_cmd; each returns exactly one result
// word on o_res with status, current ID, count and a single-member flag. Each
// command has an execute step, where the row of slot cells compares the key,
// shifts or loads and the pointer is updated, and a result step, where the
// result word is formed, when the next command may already be taken. A
// finished word waits in the output register without holding up the next
// command's update. IDs are kept in their low ID_BITS bits (at most 16). No
// clearing pass after reset: slots at or past the member count are never read.
`include "circular_turn_rotation_list_assert.svh"

module circular_turn_rotation_list import ctrl_pkg::*; #(
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctrl_stream_if.sink   i_cmd,
    ctrl_stream_if.source o_res
);

    localparam int SW    = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int IDX_W = $clog2(MAX_MEMBERS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op;
    logic [SW-1:0]    r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [ST_W-1:0]  r_status, n_status;
    t_res             r_res;
    logic             r_res_vld;

    logic             w_accept;
    logic             w_out_free;
    logic             w_load;
    logic [SW-1:0]    w_id    [MAX_MEMBERS];
    t_cell_stat       w_stat  [MAX_MEMBERS];
    logic             w_found [MAX_MEMBERS+1];
    t_cell_cmd        w_cmd   [MAX_MEMBERS];
    logic             w_first_at_cur;
    logic [CNT_W:0]   w_adv;

    // handshake
    assign w_out_free  = !r_res_vld || o_res.ready;
    assign w_load      = (r_state == S_RESULT) && w_out_free;
    assign i_cmd.ready = (r_state == S_IDLE) || w_load;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // row of slot cells
    assign w_found[0] = 1'b0;
    for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
        logic [SW-1:0] w_next;
        if (g < MAX_MEMBERS - 1) begin : g_mid
            assign w_next = w_id[g+1];
        end else begin : g_tail
            assign w_next = w_id[g];
        end

        assign w_cmd[g].add_here  = (r_state == S_EXEC) && (r_op == OP_ADD)
                                    && (CNT_W'(g) == r_count);
        assign w_cmd[g].remove_en = (r_state == S_EXEC) && (r_op == OP_REMOVE);

        ctrl_cell #(
            .ID_W (SW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_key     (r_key),
            .i_next_id (w_next),
            .i_found   (w_found[g]),
            .i_active  (CNT_W'(g) < r_count),
            .i_cmd     (w_cmd[g]),
            .o_id      (w_id[g]),
            .o_stat    (w_stat[g])
        );
        assign w_found[g+1] = w_stat[g].found;
    end

    // first match sits at the current slot
    assign w_first_at_cur = w_stat[r_cur].hit && !w_found[CNT_W'(r_cur)];

    // pointer advance modulo count
    always_comb begin
        w_adv = (CNT_W+1)'(r_cur) + ((r_op == OP_ADV2) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
        if (w_adv >= {1'b0, r_count}) begin
            w_adv = w_adv - {1'b0, r_count};
        end
        if (w_adv >= {1'b0, r_count}) begin
            w_adv = w_adv - {1'b0, r_count};
        end
    end

    // command execution
    always_comb begin
        n_count  = r_count;
        n_cur    = r_cur;
        n_status = ST_DONE;
        case (r_op)
            OP_ADD: begin
                if (r_count == CNT_W'(MAX_MEMBERS)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_found[MAX_MEMBERS]) begin
                    n_status = ST_NOT_FOUND;
                end else if (r_count == CNT_W'(1)) begin
                    n_status = ST_LAST_REMOVED;
                    n_count  = '0;
                    n_cur    = '0;
                end else begin
                    n_count = r_count - 1'b1;
                    if (w_first_at_cur) begin
                        // removed current tail wraps to head
                        if (CNT_W'(r_cur) == r_count - 1'b1) begin
                            n_cur = '0;
                        end
                    end else if (w_found[CNT_W'(r_cur)]) begin
                        n_cur = r_cur - 1'b1;
                    end
                end
            end
            OP_ADV1, OP_ADV2: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_cur = w_adv[IDX_W-1:0];
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_load) n_state = w_accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
                r_cur   <= n_cur;
            end
            if (w_load) begin
                r_res_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // command capture, status and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(i_cmd.data.operation);
            r_key <= i_cmd.data.player_id[SW-1:0];
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
        end
        if (w_load) begin
            r_res.status        <= r_status;
            r_res.current_id    <= (r_count != '0) ? ID_PORT_W'(w_id[r_cur]) : '0;
            r_res.current_valid <= (r_count != '0);
            r_res.member_count  <= CNT_PORT_W'(r_count);
            r_res.sole_member   <= (r_count == CNT_W'(1));
        end
    end

    assign o_res.valid = r_res_vld;
    assign o_res.data  = r_res;

    // checks
    `CTRL_ASSERT_IMP(a_cur_in_range, i_clk, i_rst_n, r_count != '0, CNT_W'(r_cur) < r_count)
    `CTRL_ASSERT_IMP(a_cur_zero_empty, i_clk, i_rst_n, r_count == '0, r_cur == '0)
    `CTRL_ASSERT_NXT(a_count_only_exec, i_clk, i_rst_n, r_state != S_EXEC, $stable(r_count))
    `CTRL_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC)

endmodule

[bench/circular_turn_rotation_list_test.sv]
`timescale 1ns / 1ps

module circular_turn_rotation_list_test;
    import ctrl_pkg::*;

    localparam int MEMBERS     = DEF_MAX_MEMBERS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_WORDS  = 100;   // last stretch of the run goes without idling
    localparam int PHASES      = 12;
    localparam int PHASE_LEN   = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ctrl_stream_if #(.T(t_cmd)) cmd_if ();
    ctrl_stream_if #(.T(t_res)) res_if ();

    circular_turn_rotation_list DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_cmd pending_cmds[$];
    t_res owed_results[$];

    // shadow of the ring: IDs head first, member count, current slot
    logic [ID_PORT_W-1:0] ring_ids[MEMBERS];
    int ring_len   = 0;
    int turn_slot  = 0;
    int ring_peak  = 0;

    int mismatch_count = 0;
    int cmds_taken     = 0;
    int words_checked  = 0;
    int status_seen[5] = '{default: 0};
    int cycle_count    = 0;
    logic pace_on      = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;

    // last stretch of the run: no idling
    function automatic logic quiet_tail();
        return pending_cmds.size() < TAIL_WORDS;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // apply one command to the shadow ring, return the word it should produce
    function automatic t_res ring_apply(t_cmd c);
        t_res r;
        int hit;
        int k;
        int steps;
        r = '0;
        r.status = ST_DONE;
        hit = -1;
        case (c.operation)
            OP_ADD: begin
                if (ring_len >= MEMBERS) begin
                    r.status = ST_FULL;
                end else begin
                    ring_ids[ring_len] = c.player_id;
                    if (ring_len == 0)
                        turn_slot = 0;
                    ring_len++;
                end
            end
            OP_REMOVE: begin
                for (k = 0; k < ring_len; k++)
                    if (hit < 0 && ring_ids[k] == c.player_id)
                        hit = k;
                if (ring_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (ring_len == 1) begin
                    ring_len  = 0;
                    turn_slot = 0;
                    r.status  = ST_LAST_REMOVED;
                end else begin
                    for (k = hit; k + 1 < ring_len; k++)
                        ring_ids[k] = ring_ids[k + 1];
                    ring_len--;
                    // removed current at the tail wraps to the head
                    if (hit == turn_slot) begin
                        if (hit >= ring_len)
                            turn_slot = 0;
                    end else if (hit < turn_slot) begin
                        turn_slot--;
                    end
                end
            end
            default: begin
                steps = (c.operation == OP_ADV1) ? 1 : 2;
                if (ring_len == 0)
                    r.status = ST_EMPTY;
                else
                    turn_slot = (turn_slot + steps) % ring_len;
            end
        endcase
        if (ring_len > ring_peak)
            ring_peak = ring_len;
        r.current_id    = (ring_len > 0) ? ring_ids[turn_slot] : '0;
        r.current_valid = ring_len > 0;
        r.member_count  = ring_len[CNT_PORT_W-1:0];
        r.sole_member   = ring_len == 1;
        return r;
    endfunction

    task automatic queue_cmd(t_op op, logic [ID_PORT_W-1:0] id);
        t_cmd c;
        c.operation = op;
        c.player_id = id;
        pending_cmds.push_back(c);
    endtask

    // driver: next command word when the channel is free, with random idle gaps while pacing is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_if.data  <= '0;
            send_gap     <= 0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (send_gap > 0) begin
                cmd_if.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pending_cmds.size() == 0) begin
                cmd_if.valid <= 1'b0;
            end else if (pace_on && !quiet_tail() && $urandom_range(0, 3) == 0) begin
                cmd_if.valid <= 1'b0;
                send_gap     <= $urandom_range(0, 5);
            end else begin
                cmd_if.valid <= 1'b1;
                cmd_if.data  <= pending_cmds.pop_front();
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (pace_on && !quiet_tail() && $urandom_range(0, 3) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 5);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted command, check each accepted result
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                owed_results.push_back(ring_apply(cmd_if.data));
                cmds_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing owed: status %0d id %h",
                                              got.status, got.current_id));
                end else begin
                    want = owed_results.pop_front();
                    words_checked++;
                    if (want.status <= ST_LAST_REMOVED)
                        status_seen[want.status]++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.current_id !== want.current_id)
                        report_mismatch($sformatf("current_id got %h expected %h",
                                                  got.current_id, want.current_id));
                    if (got.current_valid !== want.current_valid)
                        report_mismatch($sformatf("current_valid got %b expected %b",
                                                  got.current_valid, want.current_valid));
                    if (got.member_count !== want.member_count)
                        report_mismatch($sformatf("member_count got %0d expected %0d",
                                                  got.member_count, want.member_count));
                    if (got.sole_member !== want.sole_member)
                        report_mismatch($sformatf("sole_member got %b expected %b",
                                                  got.sole_member, want.sole_member));
                end
            end
        end
    end

    // cycle limit and periodic reshuffle of the idle pace
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            pace_on <= $urandom_range(0, 2) != 0;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("circular_turn_rotation_list regression: fail");
            $finish;
        end
    end

    initial begin
        logic [ID_PORT_W-1:0] id_pool[8];
        int add_pct;
        int pick;
        int p;
        int n;
        logic [ID_PORT_W-1:0] id;

        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;

        // directed: empty ring, one and two members, tail removal, duplicates
        queue_cmd(OP_REMOVE, 16'h1234);
        queue_cmd(OP_ADV1, 16'hFFFF);
        queue_cmd(OP_ADV2, 16'h0000);
        queue_cmd(OP_ADD, 16'h0000);
        queue_cmd(OP_ADV1, 16'h5555);
        queue_cmd(OP_ADV2, 16'hAAAA);
        queue_cmd(OP_REMOVE, 16'hFFFF);
        queue_cmd(OP_ADD, 16'hFFFF);
        queue_cmd(OP_ADV2, 16'h0000);
        queue_cmd(OP_ADV1, 16'h0000);
        queue_cmd(OP_REMOVE, 16'hFFFF);     // current is the tail
        queue_cmd(OP_REMOVE, 16'h0000);     // only member left
        queue_cmd(OP_ADD, 16'hA5A5);
        queue_cmd(OP_ADD, 16'h5A5A);
        queue_cmd(OP_ADD, 16'hA5A5);
        queue_cmd(OP_ADV2, 16'h0000);
        queue_cmd(OP_REMOVE, 16'hA5A5);     // first match sits before current
        queue_cmd(OP_REMOVE, 16'hA5A5);
        queue_cmd(OP_REMOVE, 16'h5A5A);

        // random phases: grow toward full, mixed, drain toward empty
        for (p = 0; p < PHASES; p++) begin
            for (n = 0; n < 8; n++)
                id_pool[n] = $urandom_range(0, 65535);
            if (p % 4 == 1) begin
                id_pool[0] = 16'h0000;
                id_pool[1] = 16'hFFFF;
            end
            case (p % 3)
                0: add_pct = 70;
                1: add_pct = 45;
                default: add_pct = 15;
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                id = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                 : id_pool[$urandom_range(0, 7)];
                if (pick < add_pct)
                    queue_cmd(OP_ADD, id);
                else if (pick < add_pct + 25)
                    queue_cmd(OP_REMOVE, id);
                else if (pick % 2 == 0)
                    queue_cmd(OP_ADV1, 16'($urandom_range(0, 65535)));
                else
                    queue_cmd(OP_ADV2, 16'($urandom_range(0, 65535)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then wait for stray words
        while (pending_cmds.size() != 0 || cmd_if.valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d commands, %0d result words checked, ring peaked at %0d members",
                 cmds_taken, words_checked, ring_peak);
        $display("statuses: done %0d, empty %0d, not found %0d, full %0d, last removed %0d",
                 status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_LAST_REMOVED]);
        if (mismatch_count == 0) begin
            $display("circular_turn_rotation_list regression: pass");
        end else begin
            $display("circular_turn_rotation_list regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ctrl_pkg.sv
rtl/ctrl_stream_if.sv
rtl/ctrl_cell.sv
rtl/circular_turn_rotation_list.sv
bench/circular_turn_rotation_list_test.sv
